/* design/sli_pkg.sv */
`timescale 1ns / 1ps

package sli_pkg;

   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_LIST   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_DELETED  = 3'd1,
      STATUS_NOTFOUND = 3'd2,
      STATUS_EMPTY    = 3'd3,
      STATUS_FULL     = 3'd4,
      STATUS_LISTED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_DEL_RD,
      ST_DEL_CMP,
      ST_LST_RD,
      ST_LST_EMIT,
      ST_RESULT
   } state_type;

endpackage

/* design/sorted_list_insert_delete_unit.sv */
`timescale 1ns / 1ps

// Channel | Direction | Ports                                               | Transfer when
// --------+-----------+-----------------------------------------------------+-----------------
// req     | in        | req_valid, req_stall, req_mode, req_value           | valid & !stall
// rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_entry_value,  | valid & !stall
//         |           | rsp_last, rsp_entry_count                           |
//
// Operation: one request is worked at a time by a sequencer around a single-port
//   entry memory with registered read data, a signed comparator and an equality
//   check; each entry visited takes a read state, then a compare/move state.
//   Insert moves entries up from the top until a smaller entry ends the scan or
//   every entry has moved; full is answered without a scan.
//   Delete scans every entry; List emits one result per entry; empty is answered
//   without a scan.
// Reset clears the entry count and control; entry memory contents are not cleared.
// A held rsp result stalls only the next emit; a new request can transfer while it waits.

module sorted_list_insert_delete_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sli_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [sli_pkg::VALUE_W-1:0]     req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sli_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [sli_pkg::VALUE_W-1:0]     rsp_entry_value,
   output logic                                   rsp_last,
   output logic [sli_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);

   // sequencer state
   sli_pkg::state_type                    state_ff, state_in;
   logic [sli_pkg::IDX_W-1:0]             idx_ff, idx_in;
   logic [sli_pkg::CNT_W-1:0]             count_ff, count_in;
   logic signed [sli_pkg::VALUE_W-1:0]    value_ff, value_in;
   sli_pkg::status_type                   status_ff, status_in;
   logic                                  found_ff, found_in;

   // entry memory, single write port and one registered read port
   logic signed [sli_pkg::VALUE_W-1:0]    entry_mem [sli_pkg::DEPTH];
   logic signed [sli_pkg::VALUE_W-1:0]    rd_data_ff;
   logic                                  rd_en;
   logic [sli_pkg::IDX_W-1:0]             rd_addr;
   logic                                  wr_en;
   logic [sli_pkg::IDX_W-1:0]             wr_addr;
   logic signed [sli_pkg::VALUE_W-1:0]    wr_data;

   // result register
   logic                                  rsp_valid_ff, rsp_valid_in;
   sli_pkg::status_type                   rsp_status_ff, rsp_status_in;
   logic signed [sli_pkg::VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic [sli_pkg::COUNT_OUT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                                  emit;
   logic                                  emit_ok;
   sli_pkg::status_type                   emit_status;
   logic signed [sli_pkg::VALUE_W-1:0]    emit_value;
   logic                                  emit_last;
   logic [sli_pkg::CNT_W-1:0]             idx_plus1;
   logic                                  hit;

   assign req_stall = (state_ff != sli_pkg::ST_IDLE);
   // the result slot is free, or is being drained this cycle
   assign emit_ok   = !rsp_valid_ff || !rsp_stall;
   assign idx_plus1 = sli_pkg::CNT_W'(idx_ff) + 1'b1;
   assign hit       = (rd_data_ff == value_ff);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = value_ff;
      emit        = 1'b0;
      emit_status = status_ff;
      emit_value  = value_ff;
      emit_last   = 1'b1;

      case (state_ff)
         sli_pkg::ST_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               found_in = 1'b0;
               case (req_mode)
                  sli_pkg::MODE_INSERT: begin
                     idx_in = sli_pkg::IDX_W'(count_ff);
                     if (count_ff == sli_pkg::CNT_W'(sli_pkg::DEPTH)) begin
                        status_in = sli_pkg::STATUS_FULL;
                        state_in  = sli_pkg::ST_RESULT;
                     end else if (count_ff == '0) begin
                        state_in = sli_pkg::ST_INS_PUT;
                     end else begin
                        state_in = sli_pkg::ST_INS_RD;
                     end
                  end
                  sli_pkg::MODE_DELETE: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = sli_pkg::STATUS_EMPTY;
                        state_in  = sli_pkg::ST_RESULT;
                     end else begin
                        state_in = sli_pkg::ST_DEL_RD;
                     end
                  end
                  sli_pkg::MODE_LIST: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        value_in  = '0;
                        status_in = sli_pkg::STATUS_EMPTY;
                        state_in  = sli_pkg::ST_RESULT;
                     end else begin
                        state_in = sli_pkg::ST_LST_RD;
                     end
                  end
                  default: begin
                     // undefined mode: consumed, no result
                     state_in = sli_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         // insert walks down from the top, moving larger-or-equal entries up one slot
         sli_pkg::ST_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff - 1'b1;
            state_in = sli_pkg::ST_INS_CMP;
         end
         sli_pkg::ST_INS_CMP: begin
            if (rd_data_ff >= value_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = rd_data_ff;
               idx_in   = idx_ff - 1'b1;
               state_in = (idx_ff == sli_pkg::IDX_W'(1)) ? sli_pkg::ST_INS_PUT
                                                         : sli_pkg::ST_INS_RD;
            end else begin
               state_in = sli_pkg::ST_INS_PUT;
            end
         end
         sli_pkg::ST_INS_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = value_ff;
            count_in  = count_ff + 1'b1;
            status_in = sli_pkg::STATUS_INSERTED;
            state_in  = sli_pkg::ST_RESULT;
         end

         // delete scans up; after the first match each entry moves down one slot
         sli_pkg::ST_DEL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = sli_pkg::ST_DEL_CMP;
         end
         sli_pkg::ST_DEL_CMP: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - 1'b1;
               wr_data = rd_data_ff;
            end
            found_in = found_ff || hit;
            if (idx_plus1 == count_ff) begin
               if (found_ff || hit) begin
                  count_in  = count_ff - 1'b1;
                  status_in = sli_pkg::STATUS_DELETED;
               end else begin
                  status_in = sli_pkg::STATUS_NOTFOUND;
               end
               state_in = sli_pkg::ST_RESULT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = sli_pkg::ST_DEL_RD;
            end
         end

         sli_pkg::ST_LST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = sli_pkg::ST_LST_EMIT;
         end
         sli_pkg::ST_LST_EMIT: begin
            if (emit_ok) begin
               emit        = 1'b1;
               emit_status = sli_pkg::STATUS_LISTED;
               emit_value  = rd_data_ff;
               emit_last   = (idx_plus1 == count_ff);
               if (idx_plus1 == count_ff) begin
                  state_in = sli_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = sli_pkg::ST_LST_RD;
               end
            end
         end

         sli_pkg::ST_RESULT: begin
            if (emit_ok) begin
               emit     = 1'b1;
               state_in = sli_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sli_pkg::ST_IDLE;
         end
      endcase
   end

   // result slot
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_value_in  = emit_value;
         rsp_last_in   = emit_last;
         rsp_count_in  = sli_pkg::COUNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sli_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sli_pkg::CNT_W'(sli_pkg::DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == sli_pkg::STATUS_FULL) |->
         rsp_count_ff == sli_pkg::COUNT_OUT_W'(sli_pkg::DEPTH))
      else $error("full status with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == sli_pkg::STATUS_EMPTY) |-> rsp_count_ff == '0)
      else $error("empty status with stored entries");

   a_list_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sli_pkg::ST_LST_EMIT) |-> sli_pkg::CNT_W'(idx_ff) < count_ff)
      else $error("list index past entry count");

endmodule

/* verif/tb_sorted_list_insert_delete_unit.sv */
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete_unit;

   // - A scoreboard keeps its own copy of the sorted table and predicts every transfer.
   // - Expected results are queued in order and matched against rsp transfers field by field.
   // - A short directed table comes first; three random phases with different
   //   req/rsp idling follow.

   localparam int CLOCK_HALF  = 5;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_WAIT = 4 * sli_pkg::DEPTH + 10;
   localparam int HOLD_CYCLES = 300;
   localparam int N_DIRECTED  = 19;
   localparam logic [sli_pkg::MODE_W-1:0]         MODE_UNUSED = 2'd3;
   localparam logic signed [sli_pkg::VALUE_W-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [sli_pkg::VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;

   typedef struct {
      sli_pkg::status_type                   status;
      logic signed [sli_pkg::VALUE_W-1:0]    entry_value;
      logic                                  last;
      logic [sli_pkg::COUNT_OUT_W-1:0]       entry_count;
   } list_result_type;

   // One directed stimulus row. When pinned is set, the typed-in result is
   // what gets checked; otherwise the scoreboard prediction is used.
   typedef struct {
      logic [sli_pkg::MODE_W-1:0]            mode;
      logic signed [sli_pkg::VALUE_W-1:0]    value;
      bit                                    pinned;
      list_result_type                       result;
   } directed_row_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_valid = 1'b0;
   logic                                     req_stall;
   logic [sli_pkg::MODE_W-1:0]               req_mode = sli_pkg::MODE_INSERT;
   logic signed [sli_pkg::VALUE_W-1:0]       req_value = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 1'b0;
   logic [sli_pkg::STATUS_W-1:0]             rsp_status;
   logic signed [sli_pkg::VALUE_W-1:0]       rsp_entry_value;
   logic                                     rsp_last;
   logic [sli_pkg::COUNT_OUT_W-1:0]          rsp_entry_count;

   // Scoreboard copy of the table
   logic signed [sli_pkg::VALUE_W-1:0]       table_entries [sli_pkg::DEPTH];
   int                                       table_count = 0;
   list_result_type                          op_results [$];
   list_result_type                          pending_results [$];

   // Pinned expectation travels with the request payload
   bit                                       pin_valid = 1'b0;
   list_result_type                          pin_result;

   int                                       req_idle_pct = 0;
   int                                       rsp_stall_pct = 0;
   int                                       rsp_hold_request = 0;
   int                                       rsp_hold_left = 0;
   int                                       error_count = 0;
   int                                       cycle_count = 0;

   directed_row_type                         directed_rows [N_DIRECTED];

   sorted_list_insert_delete_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Run limit; sized far beyond the slowest legal run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_sorted_list_insert_delete_unit: FAIL");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Scoreboard prediction
   // --------------------------------------------------------------------------

   function automatic void note_result(input sli_pkg::status_type status,
                                       input logic signed [sli_pkg::VALUE_W-1:0] value,
                                       input logic last);
      list_result_type r;
      r.status      = status;
      r.entry_value = value;
      r.last        = last;
      r.entry_count = table_count[sli_pkg::COUNT_OUT_W-1:0];
      op_results.push_back(r);
   endfunction

   // Apply one request to the scoreboard table; results land in op_results.
   function automatic void apply_list_op(input logic [sli_pkg::MODE_W-1:0] mode,
                                         input logic signed [sli_pkg::VALUE_W-1:0] value);
      int pos;
      int idx;
      op_results.delete();
      case (mode)
         sli_pkg::MODE_INSERT: begin
            if (table_count >= sli_pkg::DEPTH) begin
               note_result(sli_pkg::STATUS_FULL, value, 1'b1);
            end else begin
               // goes after every smaller entry, so ahead of equal ones
               pos = 0;
               while (pos < table_count && table_entries[pos] < value) pos++;
               for (idx = table_count; idx > pos; idx--)
                  table_entries[idx] = table_entries[idx-1];
               table_entries[pos] = value;
               table_count++;
               note_result(sli_pkg::STATUS_INSERTED, value, 1'b1);
            end
         end
         sli_pkg::MODE_DELETE: begin
            if (table_count == 0) begin
               note_result(sli_pkg::STATUS_EMPTY, value, 1'b1);
            end else begin
               pos = 0;
               while (pos < table_count && table_entries[pos] != value) pos++;
               if (pos >= table_count) begin
                  note_result(sli_pkg::STATUS_NOTFOUND, value, 1'b1);
               end else begin
                  for (idx = pos; idx + 1 < table_count; idx++)
                     table_entries[idx] = table_entries[idx+1];
                  table_count--;
                  note_result(sli_pkg::STATUS_DELETED, value, 1'b1);
               end
            end
         end
         sli_pkg::MODE_LIST: begin
            if (table_count == 0) begin
               note_result(sli_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (idx = 0; idx < table_count; idx++)
                  note_result(sli_pkg::STATUS_LISTED, table_entries[idx],
                              idx + 1 == table_count);
            end
         end
         default: ;  // unused mode: no state change, no result
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge. A result can never
   // belong to the request that transfers at the same edge, so results are
   // checked before the new request is predicted.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: status %0d entry_value %0d last %0d count %0d",
                      rsp_status, rsp_entry_value, rsp_last, rsp_entry_count);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_entry_value !== want.entry_value) begin
                  $error("entry_value: expected %0d, got %0d",
                         want.entry_value, rsp_entry_value);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_entry_count);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_list_op(req_mode, req_value);
            if (pin_valid) begin
               pending_results.push_back(pin_result);
            end else begin
               foreach (op_results[k]) pending_results.push_back(op_results[k]);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random stall, or a long hold-off counted here.
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // --------------------------------------------------------------------------
   // Sender
   // --------------------------------------------------------------------------

   // Called at a falling edge; returns at the falling edge after the transfer.
   // valid stays high into the next item unless that item idles first.
   task automatic send_item(input logic [sli_pkg::MODE_W-1:0] mode,
                            input logic signed [sli_pkg::VALUE_W-1:0] value,
                            input bit pinned,
                            input list_result_type pin);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_value  <= value;
      pin_valid  <= pinned;
      pin_result <= pin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Sender pauses until every expected result has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return VALUE_MAX;
      if (r < 8) return VALUE_MIN;
      if (r < 11) return '0;
      if (r < 14) return -1;
      if (r < 50) return $signed($urandom_range(0, 15)) - 8;  // small pool, many duplicates
      return $urandom;
   endfunction

   // Deletes mostly target a value that is stored, so the shift path is exercised.
   function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_delete_value();
      if (table_count > 0 && $urandom_range(0, 99) < 70)
         return table_entries[$urandom_range(0, table_count - 1)];
      return pick_value();
   endfunction

   task automatic random_phase(input int n_items, input int ins_pct,
                               input int del_pct, input int lst_pct);
      list_result_type none;
      int r;
      none = '{sli_pkg::STATUS_LISTED, '0, 1'b0, '0};
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct)
            send_item(sli_pkg::MODE_INSERT, pick_value(), 1'b0, none);
         else if (r < ins_pct + del_pct)
            send_item(sli_pkg::MODE_DELETE, pick_delete_value(), 1'b0, none);
         else if (r < ins_pct + del_pct + lst_pct)
            send_item(sli_pkg::MODE_LIST, $urandom, 1'b0, none);
         else
            send_item(MODE_UNUSED, $urandom, 1'b0, none);
      end
   endtask

   initial begin
      // unpinned rows are checked against the scoreboard
      directed_rows = '{
         '{sli_pkg::MODE_LIST,   32'sd0,     1'b1,
           '{sli_pkg::STATUS_EMPTY,    32'sd0,     1'b1, 5'd0}},
         '{sli_pkg::MODE_DELETE, 32'sd5,     1'b1,
           '{sli_pkg::STATUS_EMPTY,    32'sd5,     1'b1, 5'd0}},
         '{MODE_UNUSED,          32'sh5A5A_A5A5, 1'b0,
           '{sli_pkg::STATUS_LISTED,   32'sd0,     1'b0, 5'd0}},
         '{sli_pkg::MODE_INSERT, VALUE_MAX,  1'b1,
           '{sli_pkg::STATUS_INSERTED, VALUE_MAX,  1'b1, 5'd1}},
         '{sli_pkg::MODE_INSERT, VALUE_MIN,  1'b1,
           '{sli_pkg::STATUS_INSERTED, VALUE_MIN,  1'b1, 5'd2}},
         '{sli_pkg::MODE_INSERT, 32'sd0,     1'b1,
           '{sli_pkg::STATUS_INSERTED, 32'sd0,     1'b1, 5'd3}},
         '{sli_pkg::MODE_INSERT, -32'sd1,    1'b1,
           '{sli_pkg::STATUS_INSERTED, -32'sd1,    1'b1, 5'd4}},
         '{sli_pkg::MODE_INSERT, 32'sd0,     1'b1,
           '{sli_pkg::STATUS_INSERTED, 32'sd0,     1'b1, 5'd5}},
         '{sli_pkg::MODE_LIST,   32'sd0,     1'b0,
           '{sli_pkg::STATUS_LISTED,   32'sd0,     1'b0, 5'd0}},
         '{sli_pkg::MODE_DELETE, 32'sd12345, 1'b1,
           '{sli_pkg::STATUS_NOTFOUND, 32'sd12345, 1'b1, 5'd5}},
         '{sli_pkg::MODE_DELETE, 32'sd0,     1'b1,
           '{sli_pkg::STATUS_DELETED,  32'sd0,     1'b1, 5'd4}},
         '{sli_pkg::MODE_DELETE, VALUE_MAX,  1'b1,
           '{sli_pkg::STATUS_DELETED,  VALUE_MAX,  1'b1, 5'd3}},
         '{sli_pkg::MODE_DELETE, VALUE_MIN,  1'b1,
           '{sli_pkg::STATUS_DELETED,  VALUE_MIN,  1'b1, 5'd2}},
         '{sli_pkg::MODE_LIST,   -32'sd1,    1'b0,
           '{sli_pkg::STATUS_LISTED,   32'sd0,     1'b0, 5'd0}},
         '{sli_pkg::MODE_DELETE, -32'sd1,    1'b1,
           '{sli_pkg::STATUS_DELETED,  -32'sd1,    1'b1, 5'd1}},
         // single entry left: a value that does not match must not be removed
         '{sli_pkg::MODE_DELETE, 32'sd7,     1'b1,
           '{sli_pkg::STATUS_NOTFOUND, 32'sd7,     1'b1, 5'd1}},
         '{sli_pkg::MODE_LIST,   32'sd0,     1'b0,
           '{sli_pkg::STATUS_LISTED,   32'sd0,     1'b0, 5'd0}},
         '{sli_pkg::MODE_DELETE, 32'sd0,     1'b1,
           '{sli_pkg::STATUS_DELETED,  32'sd0,     1'b1, 5'd0}},
         '{sli_pkg::MODE_LIST,   VALUE_MAX,  1'b1,
           '{sli_pkg::STATUS_EMPTY,    32'sd0,     1'b1, 5'd0}}
      };

      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first idling mix: sender 22%, receiver 49%
      req_idle_pct  = 22;
      rsp_stall_pct = 49;
      @(negedge clock);
      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].value,
                   directed_rows[i].pinned, directed_rows[i].result);
      drain_results();

      // insert-heavy: fills the table and keeps hitting the full refusal
      random_phase(52, 70, 12, 14);
      drain_results();

      // swapped idling; delete-heavy, drains down to the empty cases
      req_idle_pct  = 49;
      rsp_stall_pct = 22;
      random_phase(48, 22, 58, 15);
      drain_results();

      // no idling; long receiver hold-off first so the unit backs up
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      rsp_hold_request = HOLD_CYCLES;
      @(negedge clock);
      random_phase(41, 45, 30, 20);
      drain_results();

      // catch any stray result after the last expected one
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_sorted_list_insert_delete_unit: PASS");
      end else begin
         $display("tb_sorted_list_insert_delete_unit: FAIL");
      end
      $finish;
   end

endmodule
